// ===== hw/rtl/tlut_pkg.sv =====
// ----------------------------------------------------------------------------
// tlut_pkg: shared types and constants of the trilinear coefficient lookup
// Grid geometry, fixed-point widths and the command carried front to back.
// ----------------------------------------------------------------------------
package tlut_pkg;

	localparam int GRID_SIZE        = 33;
	localparam int MAX_COEFFS       = 8;
	localparam int WEIGHT_FRAC_BITS = 12;
	localparam int RESULT_LIMIT     = 8;
	localparam int COEFF_LIMIT      = (MAX_COEFFS < RESULT_LIMIT) ? MAX_COEFFS : RESULT_LIMIT;

	localparam int NODE_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int DEPTH      = NODE_COUNT * MAX_COEFFS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int NODE_W     = $clog2(NODE_COUNT);

	localparam int IDX_W   = 6;                       // node coordinate width
	localparam int SLOT_W  = 3;
	localparam int CNT_W   = 4;
	localparam int VAL_W   = 16;
	localparam int CHAN_W  = 8;
	localparam int FRAC_W  = WEIGHT_FRAC_BITS + 1;    // fraction runs 0..2^F
	localparam int W2_W    = 2 * FRAC_W;
	localparam int VB_W    = VAL_W + FRAC_W;
	localparam int PROD_W  = VB_W + W2_W;
	localparam int ACC_W   = VAL_W + 3 * WEIGHT_FRAC_BITS + 1;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  nr;
		logic [IDX_W-1:0]  ng;
		logic [IDX_W-1:0]  nb;
		logic [SLOT_W-1:0] wslot;
		logic [VAL_W-1:0]  wval;
		logic [IDX_W-1:0]  ri;
		logic [IDX_W-1:0]  gi;
		logic [IDX_W-1:0]  bi;
		logic [FRAC_W-1:0] fr;
		logic [FRAC_W-1:0] fg;
		logic [FRAC_W-1:0] fb;
		logic [CNT_W-1:0]  n;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WRITE = 2'd1,
		ST_BASE  = 2'd2,
		ST_RUN   = 2'd3
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hw/rtl/tlut_front.sv =====
// ----------------------------------------------------------------------------
// tlut_front: command intake
// Registers each item, drops out-of-range writes and turns colours into
// clamped cell indices and weights before queueing.
// ----------------------------------------------------------------------------
module tlut_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [tlut_pkg::CHAN_W-1:0]   red,
	input  logic [tlut_pkg::CHAN_W-1:0]   green,
	input  logic [tlut_pkg::CHAN_W-1:0]   blue,
	input  logic [tlut_pkg::IDX_W-1:0]    node_r,
	input  logic [tlut_pkg::IDX_W-1:0]    node_g,
	input  logic [tlut_pkg::IDX_W-1:0]    node_b,
	input  logic [tlut_pkg::SLOT_W-1:0]   write_slot,
	input  logic [tlut_pkg::VAL_W-1:0]    write_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlut_pkg::CNT_W-1:0]    cfg_data,
	input  tlut_pkg::q_status_t           q_stat,
	output logic                          push,
	output tlut_pkg::cmd_t                push_cmd
);

	localparam int F      = tlut_pkg::WEIGHT_FRAC_BITS;
	localparam int POS_NUM = (tlut_pkg::GRID_SIZE - 1) * (2 ** F);
	localparam int POS_Q  = POS_NUM / 255;
	localparam int POS_R  = POS_NUM % 255;
	localparam int POS_W  = $clog2(POS_NUM + 1);
	localparam int Y_W    = 17;

	logic                         valid_s1;
	logic                         op_s1;
	logic [tlut_pkg::CHAN_W-1:0]  red_s1, green_s1, blue_s1;
	logic [tlut_pkg::IDX_W-1:0]   nr_s1, ng_s1, nb_s1;
	logic [tlut_pkg::SLOT_W-1:0]  wslot_s1;
	logic [tlut_pkg::VAL_W-1:0]   wval_s1;
	logic [tlut_pkg::CNT_W-1:0]   coeff_count_q;
	logic                         take;
	logic                         write_ok;
	logic [tlut_pkg::CNT_W-1:0]   n_eff;

	// pos = floor(c * (G-1) * 2^F / 255) = c*Q + floor(c*R/255), c*R < 2^16
	function automatic logic [tlut_pkg::IDX_W+tlut_pkg::FRAC_W-1:0] chan_pos(
		input logic [tlut_pkg::CHAN_W-1:0] c
	);
		logic [Y_W-1:0]              y;
		logic [Y_W-1:0]              corr;
		logic [POS_W-1:0]            pos;
		logic [POS_W-1:0]            hi;
		logic [tlut_pkg::IDX_W-1:0]  idx;
		logic [POS_W-1:0]            frac;
		y    = Y_W'(c) * Y_W'(POS_R);
		corr = (y + (y >> 8) + Y_W'(1)) >> 8;
		pos  = POS_W'(c) * POS_W'(POS_Q) + POS_W'(corr);
		hi   = pos >> F;
		if (hi > POS_W'(tlut_pkg::GRID_SIZE - 2)) begin
			idx = tlut_pkg::IDX_W'(tlut_pkg::GRID_SIZE - 2);
		end else begin
			idx = tlut_pkg::IDX_W'(hi);
		end
		frac = pos - (POS_W'(idx) << F);
		return {idx, tlut_pkg::FRAC_W'(frac)};
	endfunction

	assign cfg_ready = 1'b1;
	assign busy      = valid_s1 & q_stat.full;
	assign take      = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_count_q <= tlut_pkg::CNT_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			coeff_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_stat.full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= opcode;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			nr_s1    <= node_r;
			ng_s1    <= node_g;
			nb_s1    <= node_b;
			wslot_s1 <= write_slot;
			wval_s1  <= write_value;
		end
	end

	always_comb begin
		write_ok = (nr_s1 < tlut_pkg::IDX_W'(tlut_pkg::GRID_SIZE))
			&& (ng_s1 < tlut_pkg::IDX_W'(tlut_pkg::GRID_SIZE))
			&& (nb_s1 < tlut_pkg::IDX_W'(tlut_pkg::GRID_SIZE))
			&& ({1'b0, wslot_s1} < (tlut_pkg::SLOT_W+1)'(tlut_pkg::MAX_COEFFS));
		if (coeff_count_q == '0) begin
			n_eff = tlut_pkg::CNT_W'(1);
		end else if (coeff_count_q > tlut_pkg::CNT_W'(tlut_pkg::COEFF_LIMIT)) begin
			n_eff = tlut_pkg::CNT_W'(tlut_pkg::COEFF_LIMIT);
		end else begin
			n_eff = coeff_count_q;
		end
	end

	always_comb begin
		push_cmd       = '0;
		push_cmd.op    = tlut_pkg::op_t'(op_s1);
		push_cmd.nr    = nr_s1;
		push_cmd.ng    = ng_s1;
		push_cmd.nb    = nb_s1;
		push_cmd.wslot = wslot_s1;
		push_cmd.wval  = wval_s1;
		{push_cmd.ri, push_cmd.fr} = chan_pos(red_s1);
		{push_cmd.gi, push_cmd.fg} = chan_pos(green_s1);
		{push_cmd.bi, push_cmd.fb} = chan_pos(blue_s1);
		push_cmd.n     = n_eff;
		push = valid_s1 & ~q_stat.full
			& ((op_s1 == tlut_pkg::OP_LOOKUP) | write_ok);
	end

endmodule

// ===== hw/rtl/tlut_queue.sv =====
// ----------------------------------------------------------------------------
// tlut_queue: two-entry command queue
// Decouples intake from the table engine.
// ----------------------------------------------------------------------------
module tlut_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tlut_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output tlut_pkg::cmd_t       head,
	output tlut_pkg::q_status_t  q_stat
);

	tlut_pkg::cmd_t  entry_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q == 2'd2;
	assign q_stat.empty = count_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/tlut_back.sv =====
// ----------------------------------------------------------------------------
// tlut_back: table engine
// Holds the coefficient memory; runs writes and trilinear blends, one
// corner read per cycle through a multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module tlut_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlut_pkg::q_status_t           q_stat,
	input  tlut_pkg::cmd_t                head,
	output logic                          pop,
	output logic                          strobe,
	output logic [tlut_pkg::SLOT_W-1:0]   slot,
	output logic [tlut_pkg::VAL_W-1:0]    blended,
	output logic                          last
);

	localparam int F = tlut_pkg::WEIGHT_FRAC_BITS;
	localparam int G = tlut_pkg::GRID_SIZE;
	localparam logic [tlut_pkg::FRAC_W-1:0] ONE = tlut_pkg::FRAC_W'(2 ** F);
	localparam logic [tlut_pkg::ACC_W-1:0]  ROUND =
		tlut_pkg::ACC_W'(1) << (3 * F - 1);

	logic [tlut_pkg::VAL_W-1:0]   mem [tlut_pkg::DEPTH];

	tlut_pkg::back_state_t        state_q, state_d;
	tlut_pkg::cmd_t               cmd_q;
	logic [tlut_pkg::NODE_W-1:0]  base_q;
	logic [2:0]                   corner_q;
	logic [tlut_pkg::SLOT_W-1:0]  slot_q;
	logic                         issue, mem_we, last_corner, last_slot;
	logic [tlut_pkg::ADDR_W-1:0]  waddr, raddr;
	logic [tlut_pkg::FRAC_W-1:0]  wr, wg, wb;

	logic                         v_s1, first_s1, lastc_s1, lasts_s1;
	logic [tlut_pkg::SLOT_W-1:0]  slot_s1;
	logic [tlut_pkg::VAL_W-1:0]   rdata_s1;
	logic [tlut_pkg::W2_W-1:0]    wrg_s1;
	logic [tlut_pkg::FRAC_W-1:0]  wb_s1;
	logic                         v_s2, first_s2, lastc_s2, lasts_s2;
	logic [tlut_pkg::SLOT_W-1:0]  slot_s2;
	logic [tlut_pkg::VB_W-1:0]    vb_s2;
	logic [tlut_pkg::W2_W-1:0]    wrg_s2;
	logic                         v_s3, first_s3, lastc_s3, lasts_s3;
	logic [tlut_pkg::SLOT_W-1:0]  slot_s3;
	logic [tlut_pkg::ACC_W-1:0]   prod_s3;
	logic [tlut_pkg::ACC_W-1:0]   acc_q, acc_sum;

	function automatic logic [tlut_pkg::NODE_W-1:0] node_of(
		input logic [tlut_pkg::IDX_W-1:0] r,
		input logic [tlut_pkg::IDX_W-1:0] g,
		input logic [tlut_pkg::IDX_W-1:0] b
	);
		return (tlut_pkg::NODE_W'(r) * tlut_pkg::NODE_W'(G) + tlut_pkg::NODE_W'(g))
			* tlut_pkg::NODE_W'(G) + tlut_pkg::NODE_W'(b);
	endfunction

	// node offset of a cube corner: bit 0 red, bit 1 green, bit 2 blue
	function automatic logic [tlut_pkg::NODE_W-1:0] corner_off(input logic [2:0] c);
		return (c[0] ? tlut_pkg::NODE_W'(G * G) : '0)
			+ (c[1] ? tlut_pkg::NODE_W'(G) : '0)
			+ (c[2] ? tlut_pkg::NODE_W'(1) : '0);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlut_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = (head.op == tlut_pkg::OP_LOOKUP)
						? tlut_pkg::ST_BASE : tlut_pkg::ST_WRITE;
				end
			end
			tlut_pkg::ST_WRITE: state_d = tlut_pkg::ST_IDLE;
			tlut_pkg::ST_BASE:  state_d = tlut_pkg::ST_RUN;
			tlut_pkg::ST_RUN: begin
				if (last_corner && last_slot) state_d = tlut_pkg::ST_IDLE;
			end
			default: state_d = tlut_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop    = 1'b0;
		issue  = 1'b0;
		mem_we = 1'b0;
		case (state_q)
			tlut_pkg::ST_IDLE:  pop    = ~q_stat.empty;
			tlut_pkg::ST_WRITE: mem_we = 1'b1;
			tlut_pkg::ST_RUN:   issue  = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		last_corner = corner_q == 3'd7;
		last_slot   = ({1'b0, slot_q} + tlut_pkg::CNT_W'(1)) == cmd_q.n;
		waddr = tlut_pkg::ADDR_W'(node_of(cmd_q.nr, cmd_q.ng, cmd_q.nb))
			* tlut_pkg::ADDR_W'(tlut_pkg::MAX_COEFFS) + tlut_pkg::ADDR_W'(cmd_q.wslot);
		raddr = tlut_pkg::ADDR_W'(base_q + corner_off(corner_q))
			* tlut_pkg::ADDR_W'(tlut_pkg::MAX_COEFFS) + tlut_pkg::ADDR_W'(slot_q);
		wr = corner_q[0] ? cmd_q.fr : ONE - cmd_q.fr;
		wg = corner_q[1] ? cmd_q.fg : ONE - cmd_q.fg;
		wb = corner_q[2] ? cmd_q.fb : ONE - cmd_q.fb;
		acc_sum = (first_s3 ? ROUND : acc_q) + prod_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tlut_pkg::ST_IDLE;
			corner_q <= '0;
			slot_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				corner_q <= corner_q + 3'd1;
				if (last_corner) begin
					slot_q <= last_slot ? '0 : slot_q + tlut_pkg::SLOT_W'(1);
				end
			end
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			strobe <= v_s3 & lastc_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if (state_q == tlut_pkg::ST_BASE) base_q <= node_of(cmd_q.ri, cmd_q.gi, cmd_q.bi);
		if (mem_we) mem[waddr] <= cmd_q.wval;
		if (issue) rdata_s1 <= mem[raddr];
		first_s1 <= corner_q == 3'd0;
		lastc_s1 <= last_corner;
		lasts_s1 <= last_slot;
		slot_s1  <= slot_q;
		wrg_s1   <= tlut_pkg::W2_W'(wr) * tlut_pkg::W2_W'(wg);
		wb_s1    <= wb;
		first_s2 <= first_s1;
		lastc_s2 <= lastc_s1;
		lasts_s2 <= lasts_s1;
		slot_s2  <= slot_s1;
		vb_s2    <= tlut_pkg::VB_W'(rdata_s1) * tlut_pkg::VB_W'(wb_s1);
		wrg_s2   <= wrg_s1;
		first_s3 <= first_s2;
		lastc_s3 <= lastc_s2;
		lasts_s3 <= lasts_s2;
		slot_s3  <= slot_s2;
		prod_s3  <= tlut_pkg::ACC_W'(tlut_pkg::PROD_W'(vb_s2) * tlut_pkg::PROD_W'(wrg_s2));
		if (v_s3) acc_q <= acc_sum;
		slot    <= slot_s3;
		last    <= lasts_s3;
		blended <= acc_sum[3*F +: tlut_pkg::VAL_W];
	end

`ifndef SYNTHESIS
	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && issue)) else $error("table read and write in one cycle");
	a_slot_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> ##8 (strobe && slot == $past(slot, 8) + 3'd1))
		else $error("results of one lookup not eight cycles apart");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == tlut_pkg::ST_WRITE || state_q == tlut_pkg::ST_BASE))
		else $error("command popped without being run");
`endif

endmodule

// ===== hw/rtl/trilinear_lut_coeff_lookup.sv =====
// ----------------------------------------------------------------------------
// trilinear_lut_coeff_lookup: 3D grid of ink coefficients, trilinear blend
// Top level joining intake, command queue and table engine.
// ----------------------------------------------------------------------------
// Usage:
//  - Items enter on start while busy is low; opcode selects a coefficient
//    write (node_r/g/b, write_slot, write_value) or a colour lookup
//    (red, green, blue). Writes outside the grid are silently dropped.
//  - A lookup gives coeff_count results (clamped to 1..8), one per slot,
//    each shown for one cycle with strobe; last marks the final slot.
//  - Each slot takes one table read per cube corner on the single memory
//    port, so the engine reads the corners of a lookup one after another.
//  - Intake holds one item and the queue two more, so busy rises only
//    when the engine falls that far behind.
//  - cfg_valid/cfg_ready write coeff_count (reset 8); write it only idle.
//  - Reset clears control state and returns coeff_count to 8; the table is
//    not cleared and reads of never-written entries are undefined.
//  - Results cannot be held off: strobe is an unconditional transfer.
// ----------------------------------------------------------------------------
module trilinear_lut_coeff_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [tlut_pkg::CHAN_W-1:0]   red,
	input  logic [tlut_pkg::CHAN_W-1:0]   green,
	input  logic [tlut_pkg::CHAN_W-1:0]   blue,
	input  logic [tlut_pkg::IDX_W-1:0]    node_r,
	input  logic [tlut_pkg::IDX_W-1:0]    node_g,
	input  logic [tlut_pkg::IDX_W-1:0]    node_b,
	input  logic [tlut_pkg::SLOT_W-1:0]   write_slot,
	input  logic [tlut_pkg::VAL_W-1:0]    write_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlut_pkg::CNT_W-1:0]    cfg_data,
	output logic                          strobe,
	output logic [tlut_pkg::SLOT_W-1:0]   slot,
	output logic [tlut_pkg::VAL_W-1:0]    blended,
	output logic                          last
);

	tlut_pkg::q_status_t  q_stat;
	tlut_pkg::cmd_t       push_cmd, head;
	logic                 push, pop;

	// intake: registers the transfer and works out cell and weights
	tlut_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.node_r      (node_r),
		.node_g      (node_g),
		.node_b      (node_b),
		.write_slot  (write_slot),
		.write_value (write_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_stat      (q_stat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	tlut_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// engine: memory, corner sequencing and multiply-accumulate
	tlut_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.head    (head),
		.pop     (pop),
		.strobe  (strobe),
		.slot    (slot),
		.blended (blended),
		.last    (last)
	);

endmodule

// ===== test/trilinear_lut_coeff_lookup_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilinear_lut_coeff_lookup_tb: self-checking bench for the coefficient LUT
// Drives coefficient writes and colour lookups through the start/busy port,
// predicts every blended result from a shadow copy of the table, and checks
// each strobed result in order across several coeff_count settings.
// ----------------------------------------------------------------------------
module trilinear_lut_coeff_lookup_tb;

	localparam int HALF_PERIOD = 2;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;      // engine plus queue depth, writes give no strobe
	localparam int FRAC_ONE    = 1 << tlut_pkg::WEIGHT_FRAC_BITS;

	// one command as presented on the intake port
	typedef struct {
		tlut_pkg::op_t                op;
		logic [tlut_pkg::CHAN_W-1:0]  red;
		logic [tlut_pkg::CHAN_W-1:0]  green;
		logic [tlut_pkg::CHAN_W-1:0]  blue;
		logic [tlut_pkg::IDX_W-1:0]   nr;
		logic [tlut_pkg::IDX_W-1:0]   ng;
		logic [tlut_pkg::IDX_W-1:0]   nb;
		logic [tlut_pkg::SLOT_W-1:0]  wslot;
		logic [tlut_pkg::VAL_W-1:0]   wval;
	} lut_cmd_t;

	typedef struct {
		logic [tlut_pkg::SLOT_W-1:0] slot;
		logic [tlut_pkg::VAL_W-1:0]  blended;
		logic                        last;
	} blend_res_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          start       = 1'b0;
	logic                          opcode      = 1'b0;
	logic [tlut_pkg::CHAN_W-1:0]   red         = '0;
	logic [tlut_pkg::CHAN_W-1:0]   green       = '0;
	logic [tlut_pkg::CHAN_W-1:0]   blue        = '0;
	logic [tlut_pkg::IDX_W-1:0]    node_r      = '0;
	logic [tlut_pkg::IDX_W-1:0]    node_g      = '0;
	logic [tlut_pkg::IDX_W-1:0]    node_b      = '0;
	logic [tlut_pkg::SLOT_W-1:0]   write_slot  = '0;
	logic [tlut_pkg::VAL_W-1:0]    write_value = '0;
	logic                          cfg_valid   = 1'b0;
	logic [tlut_pkg::CNT_W-1:0]    cfg_data    = '0;
	logic                          busy;
	logic                          cfg_ready;
	logic                          strobe;
	logic [tlut_pkg::SLOT_W-1:0]   slot;
	logic [tlut_pkg::VAL_W-1:0]    blended;
	logic                          last;

	trilinear_lut_coeff_lookup u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.node_r      (node_r),
		.node_g      (node_g),
		.node_b      (node_b),
		.write_slot  (write_slot),
		.write_value (write_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.slot        (slot),
		.blended     (blended),
		.last        (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// shadow state
	logic [tlut_pkg::VAL_W-1:0] shadow_coeffs [int];   // keyed by flat table address
	logic [tlut_pkg::CNT_W-1:0] coeff_count_q = tlut_pkg::CNT_W'(8);
	blend_res_t                 blend_expect [$];
	lut_cmd_t                   cmd_pending [$];

	// stimulus bookkeeping: nodes whose every slot is scheduled to be written
	bit               node_planned [int];
	int               planned_list [$];

	int  mismatches    = 0;
	int  results_seen  = 0;
	int  lookups_sent  = 0;
	int  writes_sent   = 0;
	int  writes_dropped = 0;
	int  cycle_count   = 0;
	int  gap_left      = 0;
	bit  no_gaps       = 1'b0;
	lut_cmd_t cur_cmd;

	function automatic int node_id(int r, int g, int b);
		return (r * tlut_pkg::GRID_SIZE + g) * tlut_pkg::GRID_SIZE + b;
	endfunction

	// fixed-point grid position of one channel: clamped cell and 0..2^F fraction
	function automatic void chan_pos(input int c, output int idx, output int frac);
		int pos;
		pos = ((c & 8'hFF) * (tlut_pkg::GRID_SIZE - 1) * FRAC_ONE) / 255;
		idx = pos >> tlut_pkg::WEIGHT_FRAC_BITS;
		if (idx > tlut_pkg::GRID_SIZE - 2)
			idx = tlut_pkg::GRID_SIZE - 2;
		frac = pos - idx * FRAC_ONE;
	endfunction

	// update the shadow table or queue the expected blends for one accepted command
	task automatic predict_cmd(input lut_cmd_t c);
		int         ri, gi, bi, fr, fg, fb, n, key;
		longint     wr [2], wg [2], wb [2];
		longint     acc;
		blend_res_t res;
		if (c.op == tlut_pkg::OP_WRITE) begin
			writes_sent++;
			if (c.nr < tlut_pkg::GRID_SIZE && c.ng < tlut_pkg::GRID_SIZE
				&& c.nb < tlut_pkg::GRID_SIZE && c.wslot < tlut_pkg::MAX_COEFFS) begin
				shadow_coeffs[node_id(c.nr, c.ng, c.nb) * tlut_pkg::MAX_COEFFS + c.wslot] =
					c.wval;
			end else begin
				writes_dropped++;
			end
			return;
		end
		lookups_sent++;
		chan_pos(c.red, ri, fr);
		chan_pos(c.green, gi, fg);
		chan_pos(c.blue, bi, fb);
		wr[0] = FRAC_ONE - fr; wr[1] = fr;
		wg[0] = FRAC_ONE - fg; wg[1] = fg;
		wb[0] = FRAC_ONE - fb; wb[1] = fb;
		n = coeff_count_q;
		if (n < 1)
			n = 1;
		if (n > tlut_pkg::COEFF_LIMIT)
			n = tlut_pkg::COEFF_LIMIT;
		for (int s = 0; s < n; s++) begin
			acc = 0;
			for (int k = 0; k < 8; k++) begin
				key = node_id(ri + (k & 1), gi + ((k >> 1) & 1), bi + ((k >> 2) & 1))
					* tlut_pkg::MAX_COEFFS + s;
				if (shadow_coeffs.exists(key))
					acc += wr[k & 1] * wg[(k >> 1) & 1] * wb[(k >> 2) & 1] * shadow_coeffs[key];
			end
			acc = (acc + (64'd1 << (3 * tlut_pkg::WEIGHT_FRAC_BITS - 1)))
				>> (3 * tlut_pkg::WEIGHT_FRAC_BITS);
			res.slot    = tlut_pkg::SLOT_W'(s);
			res.blended = acc[tlut_pkg::VAL_W-1:0];
			res.last    = (s == n - 1);
			blend_expect.insert(blend_expect.size(), res);
		end
	endtask

	// mostly back-to-back, sometimes a short pause, rarely a long one
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_write(input int r, input int g, input int b, input int s, input int v);
		lut_cmd_t c;
		c = '{op: tlut_pkg::OP_WRITE, red: tlut_pkg::CHAN_W'($urandom),
			green: tlut_pkg::CHAN_W'($urandom), blue: tlut_pkg::CHAN_W'($urandom),
			nr: tlut_pkg::IDX_W'(r), ng: tlut_pkg::IDX_W'(g), nb: tlut_pkg::IDX_W'(b),
			wslot: tlut_pkg::SLOT_W'(s), wval: tlut_pkg::VAL_W'(v)};
		cmd_pending.insert(cmd_pending.size(), c);
	endtask

	// a lookup, preceded by writes filling every slot of any corner node not yet covered,
	// so that no never-written entry is ever read
	task automatic queue_lookup(input int r, input int g, input int b);
		int       ri, gi, bi, f, id;
		lut_cmd_t c;
		chan_pos(r, ri, f);
		chan_pos(g, gi, f);
		chan_pos(b, bi, f);
		for (int k = 0; k < 8; k++) begin
			id = node_id(ri + (k & 1), gi + ((k >> 1) & 1), bi + ((k >> 2) & 1));
			if (!node_planned.exists(id)) begin
				node_planned[id] = 1'b1;
				planned_list.insert(planned_list.size(), id);
				for (int s = 0; s < tlut_pkg::MAX_COEFFS; s++)
					queue_write(ri + (k & 1), gi + ((k >> 1) & 1), bi + ((k >> 2) & 1), s,
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 32768));
			end
		end
		c = '{op: tlut_pkg::OP_LOOKUP, red: tlut_pkg::CHAN_W'(r),
			green: tlut_pkg::CHAN_W'(g), blue: tlut_pkg::CHAN_W'(b),
			nr: tlut_pkg::IDX_W'($urandom), ng: tlut_pkg::IDX_W'($urandom),
			nb: tlut_pkg::IDX_W'($urandom), wslot: tlut_pkg::SLOT_W'($urandom),
			wval: tlut_pkg::VAL_W'($urandom)};
		cmd_pending.insert(cmd_pending.size(), c);
	endtask

	// channel value inside the lowest or the highest cell, full scale included
	function automatic int pick_chan(input bit high_end);
		if (high_end)
			return $urandom_range(248, 255);
		return $urandom_range(0, 7);
	endfunction

	task automatic queue_random(input int lookups);
		int r, id;
		bit he;
		for (int i = 0; i < lookups; i++) begin
			he = $urandom_range(0, 1);
			queue_lookup(pick_chan(he), pick_chan(he), pick_chan(he));
			r = $urandom_range(0, 9);
			if (r < 2) begin
				// noise: any coordinates, mostly outside the grid
				queue_write($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 65535));
			end else if (r < 5) begin
				// overwrite one slot of a node already covered
				id = planned_list[$urandom_range(0, planned_list.size() - 1)];
				queue_write(id / (tlut_pkg::GRID_SIZE * tlut_pkg::GRID_SIZE),
					(id / tlut_pkg::GRID_SIZE) % tlut_pkg::GRID_SIZE,
					id % tlut_pkg::GRID_SIZE, $urandom_range(0, 7), $urandom_range(0, 65535));
			end
		end
	endtask

	// configuration transfer, only called with the engine idle
	task automatic write_coeff_count(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= tlut_pkg::CNT_W'(v);
		do
			@(posedge clk);
		while (!cfg_ready);
		coeff_count_q = tlut_pkg::CNT_W'(v);
		cfg_valid <= 1'b0;
	endtask

	// hold off until the sender is empty and every expected result is in
	task automatic wait_drained();
		do begin
			do
				@(posedge clk);
			while (cmd_pending.size() != 0 || start || blend_expect.size() != 0);
			repeat (DRAIN_WAIT) @(posedge clk);
		end while (cmd_pending.size() != 0 || start || blend_expect.size() != 0);
	endtask

	// driver: predict at each transfer, then present the next command or a gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predict_cmd(cur_cmd);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_pending.size() != 0) begin
					cur_cmd = cmd_pending.pop_front();
					start       <= 1'b1;
					opcode      <= cur_cmd.op;
					red         <= cur_cmd.red;
					green       <= cur_cmd.green;
					blue        <= cur_cmd.blue;
					node_r      <= cur_cmd.nr;
					node_g      <= cur_cmd.ng;
					node_b      <= cur_cmd.nb;
					write_slot  <= cur_cmd.wslot;
					write_value <= cur_cmd.wval;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe is a transfer, matched against the oldest expectation
	always @(posedge clk) begin
		blend_res_t e;
		if (arst_n && strobe) begin
			results_seen++;
			if (blend_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: slot %0d blended %0d last %0b",
						slot, blended, last);
			end else begin
				e = blend_expect.pop_front();
				if (slot !== e.slot || blended !== e.blended || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp slot %0d blended %0d last %0b, got %0d %0d %0b",
							e.slot, e.blended, e.last, slot, blended, last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("trilinear_lut_coeff_lookup regression: fail");
			$finish;
		end
	end

	initial begin
		int count_settings [6];
		count_settings = '{8, 1, 0, 15, 3, 0};
		count_settings[5] = $urandom_range(0, 15);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: both ends of the scale, extreme values, writes off the grid
		write_coeff_count(count_settings[0]);
		queue_lookup(0, 0, 0);
		queue_lookup(255, 255, 255);
		queue_write(0, 0, 0, 1, 32768);
		queue_write(0, 0, 0, 2, 65535);
		queue_write(33, 0, 0, 0, 12345);     // one past the grid on red
		queue_write(0, 63, 0, 0, 777);
		queue_write(0, 0, 40, 3, 999);
		queue_write(63, 63, 63, 7, 65535);
		queue_write(32, 32, 32, 7, 0);
		queue_lookup(0, 0, 0);
		queue_lookup(7, 7, 7);
		queue_lookup(248, 255, 250);
		queue_lookup(254, 255, 254);
		queue_lookup(1, 6, 3);
		wait_drained();

		// random phases across coeff_count settings, incl. zero and above the limit
		for (int p = 1; p < 6; p++) begin
			no_gaps = (p == 2);
			write_coeff_count(count_settings[p]);
			queue_random(2);
			wait_drained();
		end

		$display("covered %0d lookups and %0d writes (%0d off the grid), %0d results checked",
			lookups_sent, writes_sent, writes_dropped, results_seen);
		$display("coeff_count settings 8, 1, 0, 15, 3 and %0d; %0d mismatches",
			count_settings[5], mismatches);
		if (mismatches == 0 && blend_expect.size() == 0) begin
			$display("trilinear_lut_coeff_lookup regression: pass");
		end else begin
			$display("trilinear_lut_coeff_lookup regression: fail");
		end
		$finish;
	end

endmodule
